>>> design/pfcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfcd_pkg
// Shared types, format codes and ordered-dither helpers for the pixel
// format converter.
// ----------------------------------------------------------------------------
package pfcd_pkg;

    localparam int PIX_IN_W  = 24;
    localparam int COORD_W   = 12;
    localparam int PIX_OUT_W = 32;
    localparam int FMT_W     = 2;

    // Source format codes (code 3 behaves as RGB888)
    localparam logic [FMT_W-1:0] SRC_555 = 2'd0;
    localparam logic [FMT_W-1:0] SRC_565 = 2'd1;
    localparam logic [FMT_W-1:0] SRC_888 = 2'd2;

    // Display format codes (code 3 behaves as ARGB8888)
    localparam logic [FMT_W-1:0] DST_565  = 2'd0;
    localparam logic [FMT_W-1:0] DST_888  = 2'd1;
    localparam logic [FMT_W-1:0] DST_8888 = 2'd2;

    // Register indexes of the configuration port
    localparam logic REG_SRC_FORMAT = 1'b0;
    localparam logic REG_DST_FORMAT = 1'b1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic [FMT_W-1:0] src_format;
        logic [FMT_W-1:0] dst_format;
    } t_fmt_cfg;

    // 3x3 patterns for 5-bit channels; bit (col3*3 + row3) of entry [low3]
    localparam logic [8:0] DITH5 [8] = '{
        9'b000010000,
        9'b001010000,
        9'b001010001,
        9'b001010101,
        9'b101010101,
        9'b101011101,
        9'b101011111,
        9'b111011111
    };

    // 2x2 patterns for the 6-bit channel; bit (col2*2 + row2) of entry [low2]
    localparam logic [3:0] DITH6 [4] = '{
        4'b0001,
        4'b1001,
        4'b1011,
        4'b1111
    };

    // Remainder by three: base-4 digits are congruent to themselves mod 3,
    // so fold the digit sum twice and finish with two compares.
    function automatic logic [1:0] mod3_12(input logic [COORD_W-1:0] v);
        logic [4:0] s1;
        logic [2:0] s2;
        logic [1:0] res;
        s1 = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4])
           + 5'(v[7:6]) + 5'(v[9:8]) + 5'(v[11:10]);
        s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
        if (s2 >= 3'd6) begin
            res = 2'(s2 - 3'd6);
        end else if (s2 >= 3'd3) begin
            res = 2'(s2 - 3'd3);
        end else begin
            res = s2[1:0];
        end
        return res;
    endfunction

    function automatic logic dith5_bit(input logic [2:0] low3,
                                       input logic [1:0] c3,
                                       input logic [1:0] r3);
        logic [3:0] idx;
        idx = {1'b0, c3, 1'b0} + {2'b00, c3} + {2'b00, r3};
        return DITH5[low3][idx];
    endfunction

    function automatic logic dith6_bit(input logic [1:0] low2,
                                       input logic c2,
                                       input logic r2);
        return DITH6[low2][{c2, r2}];
    endfunction

endpackage

>>> design/pfcd_dither.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfcd_dither
// Narrows an RGB888 pixel to RGB565 with position-dependent ordered dither
// and saturation at the channel maximum.
// ----------------------------------------------------------------------------
module pfcd_dither
    import pfcd_pkg::*;
(
    input  logic [PIX_IN_W-1:0] i_pixel,
    input  logic [COORD_W-1:0]  i_column,
    input  logic [COORD_W-1:0]  i_row,
    output logic [15:0]         o_pixel565
);

    logic [7:0] r8, g8, b8;
    logic [1:0] c3, r3;
    logic [5:0] r_sum, b_sum;
    logic [6:0] g_sum;
    logic [4:0] r5, b5;
    logic [5:0] g6;

    always_comb begin
        r8 = i_pixel[23:16];
        g8 = i_pixel[15:8];
        b8 = i_pixel[7:0];
        c3 = mod3_12(i_column);
        r3 = mod3_12(i_row);

        r_sum = {1'b0, r8[7:3]} + 6'(dith5_bit(r8[2:0], c3, r3));
        b_sum = {1'b0, b8[7:3]} + 6'(dith5_bit(b8[2:0], c3, r3));
        g_sum = {1'b0, g8[7:2]} + 7'(dith6_bit(g8[1:0], i_column[0], i_row[0]));

        // saturate on carry out of the channel width
        r5 = r_sum[5] ? 5'h1F : r_sum[4:0];
        b5 = b_sum[5] ? 5'h1F : b_sum[4:0];
        g6 = g_sum[6] ? 6'h3F : g_sum[5:0];

        o_pixel565 = {r5, g6, b5};
    end

endmodule

>>> design/pfcd_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfcd_convert
// Format selection: 555 remap, 565 widening by bit replication, dithered
// narrowing and alpha fill, chosen by the source and display formats.
// ----------------------------------------------------------------------------
module pfcd_convert
    import pfcd_pkg::*;
(
    input  t_fmt_cfg             i_cfg,
    input  logic [PIX_IN_W-1:0]  i_pixel,
    input  logic [COORD_W-1:0]   i_column,
    input  logic [COORD_W-1:0]   i_row,
    output logic [PIX_OUT_W-1:0] o_pixel
);

    logic [15:0] dith565;
    logic [15:0] p565;
    logic [23:0] wide888;
    logic [23:0] p888;
    logic        src_16bit;

    pfcd_dither u_dither (
        .i_pixel    (i_pixel),
        .i_column   (i_column),
        .i_row      (i_row),
        .o_pixel565 (dith565)
    );

    always_comb begin
        src_16bit = (i_cfg.src_format == SRC_555) || (i_cfg.src_format == SRC_565);

        // move 555 into 565 positions, green low bit zero
        if (i_cfg.src_format == SRC_555) begin
            p565 = {i_pixel[14:10], i_pixel[9:5], 1'b0, i_pixel[4:0]};
        end else begin
            p565 = i_pixel[15:0];
        end

        wide888 = {p565[15:11], p565[15:13],
                   p565[10:5],  p565[10:9],
                   p565[4:0],   p565[4:2]};

        p888 = src_16bit ? wide888 : i_pixel;

        unique case (i_cfg.dst_format)
            DST_565: begin
                o_pixel = {16'h0000, (src_16bit ? p565 : dith565)};
            end
            DST_888: begin
                o_pixel = {8'h00, p888};
            end
            default: begin
                o_pixel = {ALPHA_OPAQUE, p888};
            end
        endcase
    end

endmodule

>>> design/pixel_format_convert_dither.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_format_convert_dither
// Converts a stream of source pixels (RGB555/565/888) with their screen
// position into display pixels (RGB565/888/ARGB8888).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_s_*: one item per pixel, tdata carries the source pixel
//   with its display column and row. Output channel o_m_*: one converted
//   pixel per accepted item, in order.
//   Configuration: write src_format (index 0) and dst_format (index 1)
//   through i_cfg_* while no item is in flight; writes take effect at once.
//   Path: input register, then the conversion logic, then the result
//   register, which drives o_m_*.
//   Throughput: one item per cycle while i_m_tready is high; the
//   conversion is a single short combinational pass between the two
//   registers.
//   Stall: when the receiver holds i_m_tready low the result register holds,
//   the input register fills, and o_s_tready drops once both are occupied.
//   Reset: both pipeline stages empty, src_format = RGB888,
//   dst_format = RGB565.
// ----------------------------------------------------------------------------
module pixel_format_convert_dither
    import pfcd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input items
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [47:0]             i_s_tdata,   // pixel_in[23:0], column[35:24], row[47:36]
    // result items
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [PIX_OUT_W-1:0]    o_m_tdata,   // pixel_out[31:0]
    // configuration writes
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_idx,
    input  logic [FMT_W-1:0]        i_cfg_wdata
);

    t_fmt_cfg              r_cfg;
    logic                  r_s1_valid;
    logic [PIX_IN_W-1:0]   r_s1_pixel;
    logic [COORD_W-1:0]    r_s1_column;
    logic [COORD_W-1:0]    r_s1_row;
    logic                  r_out_valid;
    logic [PIX_OUT_W-1:0]  r_out_pixel;

    logic                  out_load;
    logic                  s1_load;
    logic [PIX_OUT_W-1:0]  n_out_pixel;

    assign out_load   = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || out_load;
    assign s1_load    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_format <= SRC_888;
            r_cfg.dst_format <= DST_565;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SRC_FORMAT: r_cfg.src_format <= i_cfg_wdata;
                REG_DST_FORMAT: r_cfg.dst_format <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_pixel  <= i_s_tdata[23:0];
            r_s1_column <= i_s_tdata[35:24];
            r_s1_row    <= i_s_tdata[47:36];
        end
    end

    pfcd_convert u_convert (
        .i_cfg    (r_cfg),
        .i_pixel  (r_s1_pixel),
        .i_column (r_s1_column),
        .i_row    (r_s1_row),
        .o_pixel  (n_out_pixel)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_pixel <= n_out_pixel;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_pixel;

    // an item waiting in the input register moves on when the result slot is free
    a_s1_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !r_out_valid |=> r_out_valid)
        else $error("input item not advanced to free result register");

    // both stages full and stalled: no new item may enter
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !i_m_tready |-> !o_s_tready)
        else $error("input accepted while pipeline full and stalled");

    // RGB565 results occupy the low half only
    a_565_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_cfg.dst_format == DST_565 |-> o_m_tdata[31:16] == 16'h0000)
        else $error("RGB565 result has upper bits set");

endmodule
